@@ design/rgbmed_pkg.sv @@
`timescale 1ns / 1ps

package rgbmed_pkg;

    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int SUM_W     = 10;
    localparam int WIN_N     = 9;
    localparam int MED_RANK  = 4;
    localparam int RANK_W    = 4;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int CFG_W     = 12;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM    = 12'd3;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0] window_t;
    typedef logic [WIN_N-1:0][SUM_W-1:0] sum_vec_t;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } tag_t;

    function automatic logic [SUM_W-1:0] chan_sum(input pixel_t p);
        return SUM_W'(p[7:0]) + SUM_W'(p[15:8]) + SUM_W'(p[23:16]);
    endfunction

endpackage

@@ design/rgbmed_rank.sv @@
`timescale 1ns / 1ps

module rgbmed_rank import rgbmed_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  window_t in_win,
    input  tag_t    in_tag,
    output logic    out_valid,
    input  logic    out_ready,
    output pixel_t  out_pixel,
    output tag_t    out_tag
);

    logic     s1_valid_reg;
    window_t  s1_win_reg;
    sum_vec_t s1_sum_reg;
    tag_t     s1_tag_reg;

    logic                          s2_valid_reg;
    window_t                       s2_win_reg;
    logic [WIN_N-1:0][WIN_N-1:0]   s2_prec_reg;
    logic [WIN_N-1:0][WIN_N-1:0]   prec_next;
    tag_t                          s2_tag_reg;

    logic   out_valid_reg;
    pixel_t out_pixel_reg;
    tag_t   out_tag_reg;

    logic       out_free;
    logic       adv2;
    logic       s2_free;
    logic       adv1;
    logic       in_acc;
    logic [WIN_N-1:0] med_sel;
    pixel_t     med_pix;

    assign out_free = !out_valid_reg || out_ready;
    assign adv2     = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || adv2;
    assign adv1     = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || adv1;
    assign in_acc   = in_valid && in_ready;

    // prec[i][j], i < j: element j ranks ahead of element i
    always_comb begin
        prec_next = '0;
        for (int i = 0; i < WIN_N; i++) begin
            for (int j = i + 1; j < WIN_N; j++) begin
                prec_next[i][j] = s1_sum_reg[j] < s1_sum_reg[i];
            end
        end
    end

    always_comb begin
        logic [RANK_W-1:0] rank;
        med_pix = '0;
        med_sel = '0;
        for (int i = 0; i < WIN_N; i++) begin
            rank = '0;
            for (int j = 0; j < WIN_N; j++) begin
                if (j > i) begin
                    rank = rank + RANK_W'(s2_prec_reg[i][j]);
                end else if (j < i) begin
                    rank = rank + RANK_W'(!s2_prec_reg[j][i]);
                end
            end
            med_sel[i] = (rank == RANK_W'(MED_RANK));
            if (med_sel[i]) begin
                med_pix = med_pix | s2_win_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_acc) begin
                s1_valid_reg <= 1'b1;
            end else if (adv1) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv1) begin
                s2_valid_reg <= 1'b1;
            end else if (adv2) begin
                s2_valid_reg <= 1'b0;
            end
            if (adv2) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s1_win_reg <= in_win;
            s1_tag_reg <= in_tag;
            for (int i = 0; i < WIN_N; i++) begin
                s1_sum_reg[i] <= chan_sum(in_win[i]);
            end
        end
        if (adv1) begin
            s2_win_reg  <= s1_win_reg;
            s2_tag_reg  <= s1_tag_reg;
            s2_prec_reg <= prec_next;
        end
        if (adv2) begin
            out_pixel_reg <= med_pix;
            out_tag_reg   <= s2_tag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_tag   = out_tag_reg;

    a_single_median: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> $onehot(med_sel))
        else $error("median select not one-hot");

    a_stage1_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted window lost at stage 1");

    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_free |=> s1_valid_reg && $stable(s1_sum_reg))
        else $error("stalled stage 1 changed");

endmodule

@@ design/rgb_median_3x3_by_channel_sum_unit.sv @@
`timescale 1ns / 1ps

// channel   dir  ports               word
// s_        in   s_tvalid/tready     s_tdata[23:0] in_pixel
// m_        out  m_tvalid/tready     m_tdata row/col/pixel, m_tlast frame_last
// cfg       in   apb psel..prdata    0x0 image_width, 0x4 image_height
//
// one pixel per cycle sustained unless m_tready stalls; a result is registered in s1, s2 and the output stage
// the line store is one read and one write per cycle at the current column,
// read ahead through a register from the next column, so no bubbles between pixels
// reset clears counters, window and pipeline; line store holds garbage
// border pixels are consumed without a result; m_tready low stalls s_tready
// only once the three ranking stages are full

module rgb_median_3x3_by_channel_sum_unit import rgbmed_pkg::*; #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // in_pixel[23:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // out_row[11:0], out_col[22:12], out_pixel[46:23]
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    function automatic logic [WW-1:0] used_width(input logic [CFG_W-1:0] w);
        logic [WW-1:0] wx;
        wx = WW'(w);
        if (w < MIN_DIM) begin
            wx = WW'(MIN_DIM);
        end
        if (wx > WW'(MAX_WIDTH)) begin
            wx = WW'(MAX_WIDTH);
        end
        return wx;
    endfunction

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] width_next;
    logic             cfg_we;
    reg_idx_t         cfg_idx;

    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    window_t          window_reg;
    window_t          window_next;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_rd_reg;
    logic [AW-1:0]      rd_addr;

    logic [WW-1:0]    w_used;
    logic [WW-1:0]    w_used_next;
    logic [WW-1:0]    col_cur;
    logic [WW-1:0]    col_nxt;
    logic [WW-1:0]    col_plus;
    logic [CFG_W-1:0] h_used;
    logic [ROW_W:0]   row_plus;
    logic             row_end;
    logic             col_end;
    logic             s_acc;
    logic             emit;
    tag_t             tag;

    logic   rk_in_ready;
    logic   rk_out_valid;
    pixel_t rk_out_pixel;
    tag_t   rk_out_tag;

    // configuration
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_comb begin
        width_next = width_reg;
        if (cfg_we && cfg_idx == REG_WIDTH) begin
            width_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // position
    assign w_used      = used_width(width_reg);
    assign w_used_next = used_width(width_next);
    assign h_used      = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    assign col_cur     = (WW'(col_reg) >= w_used) ? w_used - WW'(1) : WW'(col_reg);
    assign col_plus    = col_cur + WW'(1);
    assign col_end     = col_plus >= w_used;
    assign row_plus    = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign row_end     = row_plus >= (ROW_W+1)'(h_used);

    assign s_tready = rk_in_ready;
    assign s_acc    = s_tvalid && s_tready;
    assign emit     = (row_reg >= ROW_W'(2)) && (col_cur >= WW'(2));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_acc) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_plus[ROW_W-1:0];
            end else begin
                col_next = col_plus[AW-1:0];
            end
        end
    end

    assign col_nxt = (WW'(col_next) >= w_used_next) ? w_used_next - WW'(1) : WW'(col_next);
    assign rd_addr = col_nxt[AW-1:0];

    // line store: low half row r-2, high half row r-1
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            line_mem[col_cur[AW-1:0]] <= {s_tdata, line_rd_reg[2*PIX_W-1:PIX_W]};
        end
        line_rd_reg <= line_mem[rd_addr];
    end

    always_comb begin
        for (int i = 0; i < WIN_N - 3; i++) begin
            window_next[i] = window_reg[i+3];
        end
        window_next[WIN_N-3] = line_rd_reg[PIX_W-1:0];
        window_next[WIN_N-2] = line_rd_reg[2*PIX_W-1:PIX_W];
        window_next[WIN_N-1] = s_tdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            window_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (s_acc) begin
                window_reg <= window_next;
            end
        end
    end

    assign tag.row  = row_reg - ROW_W'(1);
    assign tag.col  = COL_W'(col_cur - WW'(1));
    assign tag.last = row_end && col_end;

    rgbmed_rank u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && emit),
        .in_ready  (rk_in_ready),
        .in_win    (window_next),
        .in_tag    (tag),
        .out_valid (rk_out_valid),
        .out_ready (m_tready),
        .out_pixel (rk_out_pixel),
        .out_tag   (rk_out_tag)
    );

    assign m_tvalid = rk_out_valid;
    assign m_tdata  = {1'b0, rk_out_pixel, rk_out_tag.col, rk_out_tag.row};
    assign m_tlast  = rk_out_tag.last;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench import rgbmed_pkg::*;;

    localparam int MAX_W = 2048;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        pixel_t           pix;
        logic             last;
    } median_t;

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_READ,
        STEP_PIXEL
    } step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        reg_idx_t          idx;
        logic [APB_DW-1:0] value;
        logic              typed;
        median_t           want;
    } dir_step_t;

    localparam median_t NO_MEDIAN = '0;

    localparam dir_step_t PLAN [0:24] = '{
        '{STEP_READ,  REG_WIDTH,  32'd640,        1'b0, NO_MEDIAN},
        '{STEP_READ,  REG_HEIGHT, 32'd480,        1'b0, NO_MEDIAN},
        '{STEP_WRITE, REG_WIDTH,  32'hABCD_E003,  1'b0, NO_MEDIAN},
        '{STEP_WRITE, REG_HEIGHT, 32'h0000_0003,  1'b0, NO_MEDIAN},
        '{STEP_READ,  REG_WIDTH,  32'd3,          1'b0, NO_MEDIAN},
        // equal channel sums everywhere: the centre of the window wins the tie
        '{STEP_PIXEL, REG_WIDTH,  32'h0000_00FF,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h0000_FF00,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_0000,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h0000_807F,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h007F_0080,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h0080_7F00,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h0055_5555,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h0000_FE01,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h007F_7F01,  1'b1,
          '{12'd1, 11'd1, 24'h7F0080, 1'b1}},
        // out-of-range sizes clamp to 3x3
        '{STEP_WRITE, REG_WIDTH,  32'h0000_0000,  1'b0, NO_MEDIAN},
        '{STEP_WRITE, REG_HEIGHT, 32'hFFFF_F002,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h0000_0000,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_FFFF,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_FFFF,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_FFFF,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h0000_0000,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_FFFF,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_FFFF,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_FFFF,  1'b0, NO_MEDIAN},
        '{STEP_PIXEL, REG_WIDTH,  32'h00FF_FFFF,  1'b1,
          '{12'd1, 11'd1, 24'hFFFFFF, 1'b1}}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;    // in_pixel[23:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;    // out_row[11:0], out_col[22:12], out_pixel[46:23]
    logic              m_tlast;    // frame_last
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // filter state mirror
    pixel_t           line_mem [2*MAX_W];
    bit               line_ok  [2*MAX_W];
    pixel_t           win      [WIN_N];
    int unsigned      col_at;
    int unsigned      row_at;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    median_t          expected_medians [$];
    pixel_t           palette [4];
    bit               calm;
    int               mismatches;
    int               medians_checked;
    int               pixels_sent;
    int               reg_writes;

    rgb_median_3x3_by_channel_sum_unit #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 50) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic int unsigned clamp_width(input logic [CFG_W-1:0] v);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > MAX_W) return MAX_W;
        return v;
    endfunction

    function automatic int unsigned clamp_height(input logic [CFG_W-1:0] v);
        return (v < MIN_DIM) ? MIN_DIM : v;
    endfunction

    function automatic int unsigned pixel_weight(input pixel_t p);
        return int'(p[7:0]) + int'(p[15:8]) + int'(p[23:16]);
    endfunction

    // fifth by channel sum, lower column-major slot first on ties
    function automatic pixel_t window_median();
        int unsigned s [WIN_N];
        int          rank;
        for (int i = 0; i < WIN_N; i++) s[i] = pixel_weight(win[i]);
        for (int i = 0; i < WIN_N; i++) begin
            rank = 0;
            for (int j = 0; j < WIN_N; j++) begin
                if (s[j] < s[i] || (s[j] == s[i] && j < i)) rank++;
            end
            if (rank == MED_RANK) return win[i];
        end
        return '0;
    endfunction

    function automatic bit filter_step(input pixel_t p, output median_t res);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        pixel_t      top;
        pixel_t      mid;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        c = col_at;
        r = row_at;
        if (c >= w) c = w - 1;
        top = line_mem[c];
        mid = line_mem[MAX_W + c];
        for (int i = 0; i < WIN_N - 3; i++) win[i] = win[i + 3];
        win[WIN_N - 3] = top;
        win[WIN_N - 2] = mid;
        win[WIN_N - 1] = p;
        line_mem[c] = mid;
        line_ok[c] = line_ok[MAX_W + c];
        line_mem[MAX_W + c] = p;
        line_ok[MAX_W + c] = 1'b1;
        res = '0;
        filter_step = 1'b0;
        if (r >= 2 && c >= 2) begin
            res.row = ROW_W'(r - 1);
            res.col = COL_W'(c - 1);
            res.pix = window_median();
            res.last = (r + 1 >= h) && (c + 1 >= w);
            filter_step = 1'b1;
        end
        if (c + 1 >= w) begin
            col_at = 0;
            row_at = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_at = c + 1;
        end
    endfunction

    // a width change inside a frame must only read stored rows already filled
    function automatic bit width_fits(input logic [CFG_W-1:0] v);
        for (int i = 0; i < clamp_width(v); i++) begin
            if (!line_ok[i] || !line_ok[MAX_W + i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic pixel_t random_pixel(input int mood);
        pixel_t base;
        int     pick;
        pick = $urandom_range(0, 9);
        if (mood == 1 && pick < 7) begin
            base = palette[$urandom_range(0, 3)];
            case ($urandom_range(0, 2))
                0: return base;
                1: return {base[15:0], base[23:16]};
                default: return {base[7:0], base[23:8]};
            endcase
        end
        if (pick == 9) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return PIX_W'(24'hFF << (8 * $urandom_range(0, 2)));
                default: return ~PIX_W'(24'hFF << (8 * $urandom_range(0, 2)));
            endcase
        end
        return PIX_W'($urandom);
    endfunction

    task automatic send_pixel(input pixel_t p, input bit typed, input median_t want);
        median_t got;
        bit      has;
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        do @(posedge aclk); while (!s_tready);
        has = filter_step(p, got);
        if (typed) begin
            expected_medians.push_back(want);
        end else if (has) begin
            expected_medians.push_back(got);
        end
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_medians.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_WIDTH) width_reg = val[CFG_W-1:0];
        else height_reg = val[CFG_W-1:0];
        reg_writes++;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic read_reg(input reg_idx_t idx, output logic [APB_DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= APB_AW'({idx, 2'b00});
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        val = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge aclk) begin : sink_check
        median_t exp_m;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_medians.size() == 0) begin
                report_mismatch($sformatf("unexpected word row %0d col %0d",
                                          m_tdata[11:0], m_tdata[22:12]));
            end else begin
                exp_m = expected_medians.pop_front();
                if (m_tdata[11:0] !== exp_m.row)
                    report_mismatch($sformatf("row %0d, want %0d", m_tdata[11:0], exp_m.row));
                if (m_tdata[22:12] !== exp_m.col)
                    report_mismatch($sformatf("col %0d, want %0d", m_tdata[22:12], exp_m.col));
                if (m_tdata[46:23] !== exp_m.pix)
                    report_mismatch($sformatf("pixel %06h, want %06h at row %0d col %0d",
                                              m_tdata[46:23], exp_m.pix, exp_m.row, exp_m.col));
                if (m_tlast !== exp_m.last)
                    report_mismatch($sformatf("frame_last %b, want %b at row %0d col %0d",
                                              m_tlast, exp_m.last, exp_m.row, exp_m.col));
                if (m_tdata[47] !== 1'b0)
                    report_mismatch("pad bit of m_tdata set");
                medians_checked++;
            end
        end
    end

    initial begin
        logic [APB_DW-1:0] rd;
        logic [CFG_W-1:0]  cand;
        int unsigned       frame_px;
        int unsigned       count;
        int                mood;
        int                phase;
        int                rand_pixels;
        bit                boundary;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        width_reg = WIDTH_RST;
        height_reg = HEIGHT_RST;
        col_at = 0;
        row_at = 0;
        for (int i = 0; i < WIN_N; i++) win[i] = '0;
        for (int i = 0; i < 2 * MAX_W; i++) begin
            line_mem[i] = '0;
            line_ok[i] = 1'b0;
        end
        mismatches = 0;
        medians_checked = 0;
        pixels_sent = 0;
        reg_writes = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (PLAN[k]) begin
            case (PLAN[k].kind)
                STEP_WRITE: begin
                    drain();
                    write_reg(PLAN[k].idx, PLAN[k].value);
                end
                STEP_READ: begin
                    drain();
                    read_reg(PLAN[k].idx, rd);
                    if (rd[CFG_W-1:0] !== PLAN[k].value[CFG_W-1:0])
                        report_mismatch($sformatf("register %s reads %0d, want %0d",
                                                  PLAN[k].idx.name(), rd[CFG_W-1:0],
                                                  PLAN[k].value[CFG_W-1:0]));
                end
                default: begin
                    send_pixel(PLAN[k].value[PIX_W-1:0], PLAN[k].typed, PLAN[k].want);
                end
            endcase
        end

        phase = 0;
        rand_pixels = 0;
        while (rand_pixels < 600) begin
            drain();
            calm = (phase >= 4 && phase < 8);
            boundary = (col_at == 0 && row_at == 0);
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: cand = CFG_W'($urandom_range(0, 2));
                    1: cand = CFG_W'($urandom_range(20, 40));
                    default: cand = CFG_W'($urandom_range(3, 10));
                endcase
                if (boundary || width_fits(cand))
                    write_reg(REG_WIDTH, {20'($urandom), cand});
            end
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 7) == 0) cand = CFG_W'($urandom_range(0, 2));
                else cand = CFG_W'($urandom_range(3, 7));
                write_reg(REG_HEIGHT, {20'($urandom), cand});
            end
            for (int i = 0; i < 4; i++) palette[i] = PIX_W'($urandom);
            mood = $urandom_range(0, 1);
            frame_px = clamp_width(width_reg) * clamp_height(height_reg);
            if ($urandom_range(0, 2) == 0) count = $urandom_range(1, 2 * frame_px);
            else count = frame_px * $urandom_range(1, 2);
            if (count > 600 - rand_pixels) count = 600 - rand_pixels;
            repeat (count) send_pixel(random_pixel(mood), 1'b0, NO_MEDIAN);
            rand_pixels += count;
            phase++;
        end
        calm = 1'b0;
        drain();

        $display("%0d pixels in, %0d medians checked, %0d register writes", pixels_sent,
                 medians_checked, reg_writes);
        $display("sizes from clamped 3x3 up to 40-pixel rows, resized mid-frame, both sides stalled");
        if (mismatches == 0 && expected_medians.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/rgbmed_pkg.sv
design/rgbmed_rank.sv
design/rgb_median_3x3_by_channel_sum_unit.sv
verif/testbench.sv
